// ===== sv/sacl_pkg.sv =====
// shared types and constants of the set-associative cache tag lookup
// no dependencies; every other file of the block but sacl_queue imports this package
package sacl_pkg;

    // default geometry
    localparam int DEF_SETS         = 64;
    localparam int DEF_WAYS         = 8;
    localparam int DEF_ADDRESS_BITS = 48;

    // fixed field widths
    localparam int ADDR_W     = 48;
    localparam int TIME_W     = 40;
    localparam int CNT_W      = 32;
    localparam int HIT_WAY_W  = 3;
    localparam int SEL_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_FIFO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd3;

    // access kind
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic       repl_fifo;
        logic [3:0] offset_bits;
        logic [2:0] index_bits;
        logic [3:0] ways_in_use;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        repl_fifo:   1'b0,
        offset_bits: 4'd6,
        index_bits:  3'd6,
        ways_in_use: 4'd8
    };

    function automatic logic [CNT_W-1:0] f_sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== sv/sacl_in_if.sv =====
// access channel of the tag lookup: one read or write access per word
// depends on sacl_pkg
interface sacl_in_if import sacl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [ADDR_W-1:0] address;

    modport source (output valid, operation, address, input ready);
    modport sink   (input valid, operation, address, output ready);
endinterface

// ===== sv/sacl_out_if.sv =====
// result channel of the tag lookup: hit, way and running traffic counts
// depends on sacl_pkg
interface sacl_out_if import sacl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [HIT_WAY_W-1:0] hit_way;
    logic [CNT_W-1:0]     memory_reads;
    logic [CNT_W-1:0]     memory_writes;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;

    modport source (output valid, hit, hit_way, memory_reads, memory_writes, hit_count,
                    miss_count, input ready);
    modport sink   (input valid, hit, hit_way, memory_reads, memory_writes, hit_count,
                    miss_count, output ready);
endinterface

// ===== sv/sacl_front.sv =====
// front end: accepts accesses and splits the address into set index and tag
// depends on sacl_pkg and sacl_in_if
module sacl_front import sacl_pkg::*; #(
    parameter  int SETS         = DEF_SETS,
    parameter  int ADDRESS_BITS = DEF_ADDRESS_BITS,
    localparam int AW           = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W,
    localparam int SET_W        = (SETS > 1) ? $clog2(SETS) : 1,
    localparam int ENTRY_W      = 1 + SET_W + AW
) (
    sacl_in_if.sink              i_in,
    input  t_cfg                 i_cfg,
    input  logic                 i_q_full,
    input  logic                 i_clearing,
    output logic                 o_push,
    output logic [ENTRY_W-1:0]   o_entry
);

    logic [AW-1:0]    addr;
    logic [AW-1:0]    tag;
    logic [SEL_W-1:0] sel;
    logic [SEL_W-1:0] sel_mask;
    logic [4:0]       tag_shift;
    logic [SET_W-1:0] set_idx;

    // reduce the raw selector below SETS by restoring subtract steps
    function automatic logic [SET_W-1:0] f_wrap(input logic [SEL_W-1:0] v);
        logic [SEL_W-1:0] r;
        r = v;
        for (int k = SEL_W - 1; k >= 0; k--) begin
            if (SETS < (1 << SEL_W) && int'(r) >= (SETS << k)) begin
                r = r - SEL_W'(SETS << k);
            end
        end
        return SET_W'(r);
    endfunction

    always_comb begin
        addr      = i_in.address[AW-1:0];
        sel_mask  = SEL_W'((8'd1 << i_cfg.index_bits) - 8'd1);
        sel       = SEL_W'(addr >> i_cfg.offset_bits) & sel_mask;
        tag_shift = {1'b0, i_cfg.offset_bits} + {2'b00, i_cfg.index_bits};
        tag       = addr >> tag_shift;
        set_idx   = f_wrap(sel);
    end

    assign i_in.ready = !i_q_full && !i_clearing;
    assign o_push     = i_in.valid && i_in.ready;
    assign o_entry    = {i_in.operation, set_idx, tag};

endmodule

// ===== sv/sacl_queue.sv =====
// two-entry queue between the front end and the lookup unit
// no package needed; the word width comes from DATA_W
module sacl_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_slot [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;
    logic              n_wr;
    logic              n_rd;
    logic [1:0]        n_cnt;

    always_comb begin
        n_wr  = r_wr ^ i_push;
        n_rd  = r_rd ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rd];

endmodule

// ===== sv/sacl_back.sv =====
// lookup unit: set memory, tag compare, victim choice, write-back and counters
// depends on sacl_pkg and sacl_out_if
module sacl_back import sacl_pkg::*; #(
    parameter  int SETS         = DEF_SETS,
    parameter  int WAYS         = DEF_WAYS,
    parameter  int ADDRESS_BITS = DEF_ADDRESS_BITS,
    localparam int AW           = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W,
    localparam int SET_W        = (SETS > 1) ? $clog2(SETS) : 1,
    localparam int ENTRY_W      = 1 + SET_W + AW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  logic [ENTRY_W-1:0] i_q_data,
    output logic               o_q_pop,
    output logic               o_clearing,
    sacl_out_if.source         o_out
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LVL   = (WAYS > 1) ? $clog2(WAYS) : 0;
    localparam int NLEAF = 1 << LVL;
    localparam int NNODE = 2 * NLEAF - 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;
    localparam logic [1:0] ST_UPD   = 2'd3;

    // set memories, one row per set
    logic [WAYS-1:0]              r_valid_mem [SETS];
    logic [WAYS-1:0][AW-1:0]      r_tag_mem   [SETS];
    logic [WAYS-1:0][TIME_W-1:0]  r_ts_mem    [SETS];

    logic [WAYS-1:0]              r_rd_valid;
    logic [WAYS-1:0][AW-1:0]      r_rd_tag;
    logic [WAYS-1:0][TIME_W-1:0]  r_rd_ts;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [SET_W-1:0]  r_clr_idx;
    logic              r_cur_op;
    logic [SET_W-1:0]  r_cur_set;
    logic [AW-1:0]     r_cur_tag;
    logic              r_hit;
    logic [WAY_W-1:0]  r_way;
    logic [TIME_W-1:0] r_time;
    logic [CNT_W-1:0]  r_reads;
    logic [CNT_W-1:0]  r_writes;
    logic [CNT_W-1:0]  r_hits;
    logic [CNT_W-1:0]  r_misses;
    logic              r_out_valid;

    logic              q_op;
    logic [SET_W-1:0]  q_set;
    logic [AW-1:0]     q_tag;

    logic [4:0]        nways;
    logic [WAYS-1:0]   en;
    logic [WAYS-1:0]   match;
    logic [WAYS-1:0]   inval;
    logic [WAY_W-1:0]  hit_idx;
    logic [WAY_W-1:0]  inv_idx;
    logic [WAY_W-1:0]  n_way;

    logic              l_p  [NLEAF];
    logic [TIME_W-1:0] l_ts [NLEAF];
    logic [WAY_W-1:0]  l_ix [NLEAF];
    logic              t_p  [NNODE];
    logic [TIME_W-1:0] t_ts [NNODE];
    logic [WAY_W-1:0]  t_ix [NNODE];

    logic                        mem_we;
    logic [SET_W-1:0]            mem_wa;
    logic [WAYS-1:0]             n_vrow;
    logic [WAYS-1:0][AW-1:0]     n_trow;
    logic [WAYS-1:0][TIME_W-1:0] n_tsrow;

    logic [WAY_W+HIT_WAY_W-1:0]  way_ext;

    assign {q_op, q_set, q_tag} = i_q_data;

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid && (!r_out_valid || o_out.ready);

    // ways searched in this set
    always_comb begin
        if (i_cfg.ways_in_use == 4'd0) begin
            nways = 5'd1;
        end else if (int'(i_cfg.ways_in_use) > WAYS) begin
            nways = 5'(WAYS);
        end else begin
            nways = {1'b0, i_cfg.ways_in_use};
        end
        for (int w = 0; w < WAYS; w++) begin
            en[w]    = (w < int'(nways));
            match[w] = en[w] && r_rd_valid[w] && (r_rd_tag[w] == r_cur_tag);
            inval[w] = en[w] && !r_rd_valid[w];
        end
        hit_idx = '0;
        inv_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_idx = WAY_W'(w);
            end
            if (inval[w]) begin
                inv_idx = WAY_W'(w);
            end
        end
    end

    // oldest-timestamp tree, left child wins ties
    for (genvar g = 0; g < NLEAF; g++) begin : g_leaf
        if (g < WAYS) begin : g_way
            assign l_p[g]  = en[g];
            assign l_ts[g] = r_rd_ts[g];
            assign l_ix[g] = WAY_W'(g);
        end else begin : g_pad
            assign l_p[g]  = 1'b0;
            assign l_ts[g] = '0;
            assign l_ix[g] = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < NLEAF; i++) begin
            t_p[NLEAF-1+i]  = l_p[i];
            t_ts[NLEAF-1+i] = l_ts[i];
            t_ix[NLEAF-1+i] = l_ix[i];
        end
        for (int i = NLEAF - 2; i >= 0; i--) begin
            if (!t_p[2*i+1] || (t_p[2*i+2] && (t_ts[2*i+2] < t_ts[2*i+1]))) begin
                t_p[i]  = t_p[2*i+2];
                t_ts[i] = t_ts[2*i+2];
                t_ix[i] = t_ix[2*i+2];
            end else begin
                t_p[i]  = t_p[2*i+1];
                t_ts[i] = t_ts[2*i+1];
                t_ix[i] = t_ix[2*i+1];
            end
        end
    end

    always_comb begin
        if (|match) begin
            n_way = hit_idx;
        end else if (|inval) begin
            n_way = inv_idx;
        end else begin
            n_way = t_ix[0];
        end
    end

    // row after the access
    always_comb begin
        n_vrow  = r_rd_valid;
        n_trow  = r_rd_tag;
        n_tsrow = r_rd_ts;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == r_way) begin
                if (!r_hit) begin
                    n_vrow[w] = 1'b1;
                    n_trow[w] = r_cur_tag;
                end
                if (!r_hit || !i_cfg.repl_fifo) begin
                    n_tsrow[w] = r_time;
                end
            end
        end
        if (r_state == ST_CLEAR) begin
            n_vrow = '0;
        end
    end

    assign mem_we = (r_state == ST_CLEAR) || (r_state == ST_UPD);
    assign mem_wa = (r_state == ST_CLEAR) ? r_clr_idx : r_cur_set;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_valid_mem[mem_wa] <= n_vrow;
            r_tag_mem[mem_wa]   <= n_trow;
            r_ts_mem[mem_wa]    <= n_tsrow;
        end
        if (o_q_pop) begin
            r_rd_valid <= r_valid_mem[q_set];
            r_rd_tag   <= r_tag_mem[q_set];
            r_rd_ts    <= r_ts_mem[q_set];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (int'(r_clr_idx) == SETS - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_q_pop) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: n_state = ST_UPD;
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_time      <= '0;
            r_reads     <= '0;
            r_writes    <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
            if (r_state == ST_UPD) begin
                r_time <= r_time + TIME_W'(1);
                if (r_cur_op == OP_WRITE) begin
                    r_writes <= f_sat_inc(r_writes);
                end
                if (r_hit) begin
                    r_hits <= f_sat_inc(r_hits);
                end else begin
                    r_misses <= f_sat_inc(r_misses);
                    r_reads  <= f_sat_inc(r_reads);
                end
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur_op  <= q_op;
            r_cur_set <= q_set;
            r_cur_tag <= q_tag;
        end
        if (r_state == ST_LOOK) begin
            r_hit <= |match;
            r_way <= n_way;
        end
    end

    assign way_ext = {{HIT_WAY_W{1'b0}}, r_way};

    assign o_out.valid         = r_out_valid;
    assign o_out.hit           = r_hit;
    assign o_out.hit_way       = way_ext[HIT_WAY_W-1:0];
    assign o_out.memory_reads  = r_reads;
    assign o_out.memory_writes = r_writes;
    assign o_out.hit_count     = r_hits;
    assign o_out.miss_count    = r_misses;

endmodule

// ===== sv/set_assoc_cache_tag_lookup_core.sv =====
// top level of the set-associative cache tag lookup with lru or fifo replacement
// depends on sacl_pkg, sacl_in_if, sacl_out_if, sacl_front, sacl_queue, sacl_back
//
//   channel   direction  handshake          word
//   i_in      in         valid / ready      operation, address
//   o_out     out        valid / ready      hit, hit_way, four saturating counts
//   i_cfg_*   in         write enable only  register index, write data
//
// the lookup unit handles one word at a time: set row read, compare and victim
// choice, row write-back
// a two-entry queue lets the front end take words while the lookup unit works
// a waiting result holds the lookup unit; the next word starts in the cycle
// the result is taken, and the front end stalls once the queue is full
// after reset a clearing pass zeroes the valid bits of every set, ready low
module set_assoc_cache_tag_lookup_core import sacl_pkg::*; #(
    parameter int SETS         = DEF_SETS,
    parameter int WAYS         = DEF_WAYS,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sacl_in_if.sink               i_in,
    sacl_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW      = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ENTRY_W = 1 + SET_W + AW;

    t_cfg               r_cfg;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic               push;
    logic               clearing;
    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] q_data;

    // configuration registers; write them only while the block is idle (the block itself does not enforce it)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REPL_FIFO:   r_cfg.repl_fifo   <= i_cfg_data[0];
                CFG_OFFSET_BITS: r_cfg.offset_bits <= i_cfg_data[3:0];
                CFG_INDEX_BITS:  r_cfg.index_bits  <= i_cfg_data[2:0];
                CFG_WAYS_IN_USE: r_cfg.ways_in_use <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // address split into set index and tag
    sacl_front #(
        .SETS         (SETS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_push     (push),
        .o_entry    (entry)
    );

    // decouples front end from the lookup unit
    sacl_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // set memory, replacement and counters
    sacl_back #(
        .SETS         (SETS),
        .WAYS         (WAYS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_out      (o_out)
    );

endmodule
